// ===== design/cfst_pkg.sv =====
// ----------------------------------------------------------------------------
// cfst_pkg
// Shared constants, codes and controller/datapath interface types for the
// CAN acceptance filter slot table.
// ----------------------------------------------------------------------------
package cfst_pkg;

    localparam int NUM_BANKS_DEF  = 14;
    localparam int MAX_ACTIVE_DEF = 28;

    localparam logic [31:0] STD_LIMIT = 32'h0000_07FF;
    localparam logic [31:0] EXT_LIMIT = 32'h1FFF_FFFF;

    localparam logic [10:0] STD_MASK_RST = 11'h7FF;
    localparam logic [28:0] EXT_MASK_RST = 29'h1FFF_FFFF;

    // configuration register indexes
    localparam logic CFG_STD_MASK = 1'b0;
    localparam logic CFG_EXT_MASK = 1'b1;

    // command modes
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_CLEAR  = 3'd2;
    localparam logic [2:0] MODE_LOOKUP = 3'd3;
    localparam logic [2:0] MODE_LIST   = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_ID    = 3'd1;
    localparam logic [2:0] STAT_BAD_MASK  = 3'd2;
    localparam logic [2:0] STAT_DUPLICATE = 3'd3;
    localparam logic [2:0] STAT_LIMIT     = 3'd4;
    localparam logic [2:0] STAT_NO_SLOT   = 3'd5;
    localparam logic [2:0] STAT_CFG_FAIL  = 3'd6;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd7;

    // slot states
    localparam logic [1:0] SLOT_INACTIVE = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE   = 2'd1;
    localparam logic [1:0] SLOT_ERROR    = 2'd2;

    // result source select
    typedef enum logic [2:0] {
        RES_NONE,
        RES_ERR,
        RES_ADD,
        RES_FOUND,
        RES_PEND
    } res_sel_t;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_inc;
        logic       cmp;
        logic       write;
        logic       remove;
        logic       clear_all;
        logic       emit;
        logic       last;
        res_sel_t   sel;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       id_bad;
        logic       mask_bad;
        logic       match;
        logic       scan_last;
        logic       found;
        logic       cnt_full;
        logic       cand_vld;
        logic       cfg_ok;
        logic       list_hit;
        logic       pend_vld;
    } dp_stat_t;

endpackage

// ===== design/can_filter_slot_table.sv =====
// ----------------------------------------------------------------------------
// can_filter_slot_table
// Table of CAN acceptance filters in banks of two slots: add, remove,
// remove all, lookup and list commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the cycle in which the last result of that command is shown, so the
// next command can be taken at the edge that ends that cycle. Each result
// appears for one cycle with done high, and the final one of a command has
// last set; the receiver cannot stall results. Remove all, unknown modes and
// adds with a bad id or mask go from dispatch straight to the result. Add,
// remove, lookup and list scan the slots one by one through the single read
// port of the slot memory, with a read state and a compare state per slot;
// remove, lookup and a duplicate add stop at the first hit. List results
// come out while the scan runs.
// ----------------------------------------------------------------------------
module can_filter_slot_table #(
    parameter int NUM_BANKS  = cfst_pkg::NUM_BANKS_DEF,
    parameter int MAX_ACTIVE = cfst_pkg::MAX_ACTIVE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        start,
    input  logic [2:0]  mode,
    input  logic [31:0] filter_id,
    input  logic [31:0] filter_mask,
    input  logic        extended,
    input  logic        configure_ok,
    input  logic [4:0]  list_limit,
    output logic        busy,
    output logic        done,
    output logic [2:0]  status,
    output logic        entry_valid,
    output logic [3:0]  bank_index,
    output logic        slot_index,
    output logic [28:0] entry_id,
    output logic [28:0] entry_mask,
    output logic        entry_extended,
    output logic [4:0]  active_total,
    output logic [3:0]  banks_in_use,
    output logic        last
);

    cfst_pkg::dp_cmd_t  cmd;
    cfst_pkg::dp_stat_t st;

    cfst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    cfst_dp #(
        .NUM_BANKS  (NUM_BANKS),
        .MAX_ACTIVE (MAX_ACTIVE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .filter_id      (filter_id),
        .filter_mask    (filter_mask),
        .extended       (extended),
        .configure_ok   (configure_ok),
        .list_limit     (list_limit),
        .cmd            (cmd),
        .st             (st),
        .done           (done),
        .status         (status),
        .entry_valid    (entry_valid),
        .bank_index     (bank_index),
        .slot_index     (slot_index),
        .entry_id       (entry_id),
        .entry_mask     (entry_mask),
        .entry_extended (entry_extended),
        .active_total   (active_total),
        .banks_in_use   (banks_in_use),
        .last           (last)
    );

endmodule

// ===== design/cfst_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfst_ctrl
// Command sequencer: dispatches a command, steps the slot scan and decides
// the outcome.
// ----------------------------------------------------------------------------
module cfst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cfst_pkg::dp_stat_t st,
    output cfst_pkg::dp_cmd_t  cmd,
    output logic               busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_READ,
        S_CMP,
        S_DECIDE,
        S_EMIT,
        S_LFLUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           code_reg, code_next;
    cfst_pkg::res_sel_t   sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= cfst_pkg::STAT_OK;
            sel_reg   <= cfst_pkg::RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.mode)
                    cfst_pkg::MODE_ADD:
                    begin
                        if (st.id_bad)
                        begin
                            code_next  = cfst_pkg::STAT_BAD_ID;
                            sel_next   = cfst_pkg::RES_NONE;
                            state_next = S_EMIT;
                        end
                        else if (st.mask_bad)
                        begin
                            code_next  = cfst_pkg::STAT_BAD_MASK;
                            sel_next   = cfst_pkg::RES_NONE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                    cfst_pkg::MODE_REMOVE, cfst_pkg::MODE_LOOKUP, cfst_pkg::MODE_LIST:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_READ;
                    end
                    cfst_pkg::MODE_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        code_next     = cfst_pkg::STAT_OK;
                        sel_next      = cfst_pkg::RES_NONE;
                        state_next    = S_EMIT;
                    end
                    default:
                    begin
                        code_next  = cfst_pkg::STAT_OK;
                        sel_next   = cfst_pkg::RES_NONE;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (st.mode == cfst_pkg::MODE_LIST)
                begin
                    // a new hit releases the held entry as a non-final result
                    if (st.list_hit && st.pend_vld)
                    begin
                        cmd.emit = 1'b1;
                        cmd.sel  = cfst_pkg::RES_PEND;
                        cmd.code = cfst_pkg::STAT_OK;
                    end
                    if (st.scan_last)
                        state_next = S_LFLUSH;
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                        state_next   = S_READ;
                    end
                end
                else if (st.match || st.scan_last)
                    state_next = S_DECIDE;
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
                case (st.mode)
                    cfst_pkg::MODE_ADD:
                    begin
                        sel_next = cfst_pkg::RES_NONE;
                        if (st.found)
                            code_next = cfst_pkg::STAT_DUPLICATE;
                        else if (st.cnt_full)
                            code_next = cfst_pkg::STAT_LIMIT;
                        else if (!st.cand_vld)
                            code_next = cfst_pkg::STAT_NO_SLOT;
                        else
                        begin
                            cmd.write = 1'b1;
                            if (st.cfg_ok)
                            begin
                                code_next = cfst_pkg::STAT_OK;
                                sel_next  = cfst_pkg::RES_ADD;
                            end
                            else
                            begin
                                code_next = cfst_pkg::STAT_CFG_FAIL;
                                sel_next  = cfst_pkg::RES_ERR;
                            end
                        end
                    end
                    cfst_pkg::MODE_REMOVE:
                    begin
                        if (st.found)
                        begin
                            cmd.remove = 1'b1;
                            code_next  = cfst_pkg::STAT_OK;
                            sel_next   = cfst_pkg::RES_FOUND;
                        end
                        else
                        begin
                            code_next = cfst_pkg::STAT_NOT_FOUND;
                            sel_next  = cfst_pkg::RES_NONE;
                        end
                    end
                    default:
                    begin
                        if (st.found)
                        begin
                            code_next = cfst_pkg::STAT_OK;
                            sel_next  = cfst_pkg::RES_FOUND;
                        end
                        else
                        begin
                            code_next = cfst_pkg::STAT_NOT_FOUND;
                            sel_next  = cfst_pkg::RES_NONE;
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_LFLUSH:
            begin
                cmd.emit   = 1'b1;
                cmd.last   = 1'b1;
                cmd.code   = cfst_pkg::STAT_OK;
                cmd.sel    = st.pend_vld ? cfst_pkg::RES_PEND : cfst_pkg::RES_NONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/cfst_dp.sv =====
// ----------------------------------------------------------------------------
// cfst_dp
// Datapath: slot memory, slot state and bank fill, scan pointer, search
// captures and the result register.
// ----------------------------------------------------------------------------
module cfst_dp #(
    parameter int NUM_BANKS  = cfst_pkg::NUM_BANKS_DEF,
    parameter int MAX_ACTIVE = cfst_pkg::MAX_ACTIVE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [28:0]        cfg_data,
    input  logic [2:0]         mode,
    input  logic [31:0]        filter_id,
    input  logic [31:0]        filter_mask,
    input  logic               extended,
    input  logic               configure_ok,
    input  logic [4:0]         list_limit,
    input  cfst_pkg::dp_cmd_t  cmd,
    output cfst_pkg::dp_stat_t st,
    output logic               done,
    output logic [2:0]         status,
    output logic               entry_valid,
    output logic [3:0]         bank_index,
    output logic               slot_index,
    output logic [28:0]        entry_id,
    output logic [28:0]        entry_mask,
    output logic               entry_extended,
    output logic [4:0]         active_total,
    output logic [3:0]         banks_in_use,
    output logic               last
);

    localparam int NSLOTS = 2 * NUM_BANKS;
    localparam int SW     = $clog2(NSLOTS);
    localparam int BW     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CW     = $clog2(MAX_ACTIVE + 1);
    localparam int BCW    = $clog2(NUM_BANKS + 1);
    localparam int NW     = $clog2(NSLOTS + 1);

    // configuration
    logic [10:0] std_def_reg;
    logic [28:0] ext_def_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_def_reg <= cfst_pkg::STD_MASK_RST;
            ext_def_reg <= cfst_pkg::EXT_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfst_pkg::CFG_STD_MASK: std_def_reg <= cfg_data[10:0];
                cfst_pkg::CFG_EXT_MASK: ext_def_reg <= cfg_data;
                default:                std_def_reg <= std_def_reg;
            endcase
        end
    end

    // command latch; a zero mask is replaced here by the default
    logic [2:0]  mode_reg;
    logic [31:0] id_reg;
    logic [31:0] mask_reg;
    logic        ext_reg;
    logic        cfg_ok_reg;
    logic [4:0]  limit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            id_reg     <= filter_id;
            ext_reg    <= extended;
            cfg_ok_reg <= configure_ok;
            limit_reg  <= list_limit;
            if (filter_mask == 32'd0)
                mask_reg <= extended ? {3'b000, ext_def_reg} : {21'd0, std_def_reg};
            else
                mask_reg <= filter_mask;
        end
    end

    logic [31:0] lim;
    assign lim = ext_reg ? cfst_pkg::EXT_LIMIT : cfst_pkg::STD_LIMIT;

    // scan pointer
    logic [SW-1:0] scan_idx_reg;
    logic [BW-1:0] scan_bank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_idx_reg <= '0;
        else if (cmd.scan_clr)
            scan_idx_reg <= '0;
        else if (cmd.scan_inc)
            scan_idx_reg <= scan_idx_reg + SW'(1);
    end

    assign scan_bank = BW'(scan_idx_reg >> 1);

    // slot memory, one read port at the scan pointer
    logic [28:0]   mem_id   [NSLOTS];
    logic [28:0]   mem_mask [NSLOTS];
    logic          mem_type [NSLOTS];
    logic [28:0]   rd_id_reg;
    logic [28:0]   rd_mask_reg;
    logic          rd_type_reg;
    logic [SW-1:0] cand_idx;
    logic [BW-1:0] cand_bank;

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem_id[cand_idx]   <= id_reg[28:0];
            mem_mask[cand_idx] <= mask_reg[28:0];
            mem_type[cand_idx] <= ext_reg;
        end
        rd_id_reg   <= mem_id[scan_idx_reg];
        rd_mask_reg <= mem_mask[scan_idx_reg];
        rd_type_reg <= mem_type[scan_idx_reg];
    end

    // slot state, bank fill and totals
    logic [1:0]     status_reg [NSLOTS];
    logic [1:0]     fill_reg   [NUM_BANKS];
    logic [CW-1:0]  act_cnt_reg;
    logic [BCW-1:0] bank_cnt_reg;
    logic [SW-1:0]  found_idx_reg;
    logic [BW-1:0]  found_bank;
    logic [1:0]     found_fill_reg;
    logic           part_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOTS; i++)
                status_reg[i] <= cfst_pkg::SLOT_INACTIVE;
            for (int b = 0; b < NUM_BANKS; b++)
                fill_reg[b] <= 2'd0;
            act_cnt_reg  <= '0;
            bank_cnt_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < NSLOTS; i++)
                status_reg[i] <= cfst_pkg::SLOT_INACTIVE;
            for (int b = 0; b < NUM_BANKS; b++)
                fill_reg[b] <= 2'd0;
            act_cnt_reg  <= '0;
            bank_cnt_reg <= '0;
        end
        else if (cmd.write)
        begin
            status_reg[cand_idx] <= cfg_ok_reg ? cfst_pkg::SLOT_ACTIVE : cfst_pkg::SLOT_ERROR;
            if (cfg_ok_reg)
            begin
                // a partly used bank goes to two, an empty bank to one
                fill_reg[cand_bank] <= part_vld_reg ? 2'd2 : 2'd1;
                if (!part_vld_reg)
                    bank_cnt_reg <= bank_cnt_reg + BCW'(1);
                act_cnt_reg <= act_cnt_reg + CW'(1);
            end
        end
        else if (cmd.remove)
        begin
            status_reg[found_idx_reg] <= cfst_pkg::SLOT_INACTIVE;
            fill_reg[found_bank]      <= found_fill_reg - 2'd1;
            act_cnt_reg               <= act_cnt_reg - CW'(1);
            if (found_fill_reg == 2'd1)
                bank_cnt_reg <= bank_cnt_reg - BCW'(1);
        end
    end

    // per-slot compare
    logic [1:0] status_rd;
    logic [1:0] fill_rd;
    logic       match;
    logic       part_hit;
    logic       empty_hit;
    logic       list_hit;
    logic       found_reg;
    logic       empty_vld_reg;
    logic       pend_vld_reg;
    logic [NW-1:0] n_reg;

    assign status_rd = status_reg[scan_idx_reg];
    assign fill_rd   = fill_reg[scan_bank];
    assign match     = (status_rd == cfst_pkg::SLOT_ACTIVE) && (id_reg[31:29] == 3'd0)
                       && (rd_id_reg == id_reg[28:0]);
    assign part_hit  = (fill_rd == 2'd1) && (status_rd != cfst_pkg::SLOT_ACTIVE)
                       && !part_vld_reg;
    assign empty_hit = (fill_rd == 2'd0) && !scan_idx_reg[0] && !empty_vld_reg;
    assign list_hit  = (status_rd == cfst_pkg::SLOT_ACTIVE)
                       && (32'(n_reg) < 32'(limit_reg)) && (32'(n_reg) < MAX_ACTIVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            part_vld_reg  <= 1'b0;
            empty_vld_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            n_reg         <= '0;
        end
        else if (cmd.scan_clr)
        begin
            found_reg     <= 1'b0;
            part_vld_reg  <= 1'b0;
            empty_vld_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            n_reg         <= '0;
        end
        else if (cmd.cmp)
        begin
            if (match)
                found_reg <= 1'b1;
            if (part_hit)
                part_vld_reg <= 1'b1;
            if (empty_hit)
                empty_vld_reg <= 1'b1;
            if (list_hit)
            begin
                pend_vld_reg <= 1'b1;
                n_reg        <= n_reg + NW'(1);
            end
        end
    end

    logic [28:0]   found_id_reg;
    logic [28:0]   found_mask_reg;
    logic          found_type_reg;
    logic [SW-1:0] part_idx_reg;
    logic [SW-1:0] empty_idx_reg;
    logic [SW-1:0] pend_idx_reg;
    logic [28:0]   pend_id_reg;
    logic [28:0]   pend_mask_reg;
    logic          pend_type_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            if (match && !found_reg)
            begin
                found_idx_reg  <= scan_idx_reg;
                found_id_reg   <= rd_id_reg;
                found_mask_reg <= rd_mask_reg;
                found_type_reg <= rd_type_reg;
                found_fill_reg <= fill_rd;
            end
            if (part_hit)
                part_idx_reg <= scan_idx_reg;
            if (empty_hit)
                empty_idx_reg <= scan_idx_reg;
            if (list_hit)
            begin
                pend_idx_reg  <= scan_idx_reg;
                pend_id_reg   <= rd_id_reg;
                pend_mask_reg <= rd_mask_reg;
                pend_type_reg <= rd_type_reg;
            end
        end
    end

    assign cand_idx   = part_vld_reg ? part_idx_reg : empty_idx_reg;
    assign cand_bank  = BW'(cand_idx >> 1);
    assign found_bank = BW'(found_idx_reg >> 1);

    always_comb
    begin
        st           = '0;
        st.mode      = mode_reg;
        st.id_bad    = id_reg > lim;
        st.mask_bad  = mask_reg > lim;
        st.match     = match;
        st.scan_last = (scan_idx_reg == SW'(NSLOTS - 1));
        st.found     = found_reg;
        st.cnt_full  = (32'(act_cnt_reg) >= MAX_ACTIVE);
        st.cand_vld  = part_vld_reg || empty_vld_reg;
        st.cfg_ok    = cfg_ok_reg;
        st.list_hit  = list_hit;
        st.pend_vld  = pend_vld_reg;
    end

    // result selection
    logic          r_has_slot;
    logic [SW-1:0] r_idx;
    logic          r_valid;
    logic [28:0]   r_id;
    logic [28:0]   r_mask;
    logic          r_type;

    always_comb
    begin
        r_has_slot = 1'b0;
        r_idx      = '0;
        r_valid    = 1'b0;
        r_id       = '0;
        r_mask     = '0;
        r_type     = 1'b0;
        case (cmd.sel)
            cfst_pkg::RES_ERR:
            begin
                r_has_slot = 1'b1;
                r_idx      = cand_idx;
            end
            cfst_pkg::RES_ADD:
            begin
                r_has_slot = 1'b1;
                r_idx      = cand_idx;
                r_valid    = 1'b1;
                r_id       = id_reg[28:0];
                r_mask     = mask_reg[28:0];
                r_type     = ext_reg;
            end
            cfst_pkg::RES_FOUND:
            begin
                r_has_slot = 1'b1;
                r_idx      = found_idx_reg;
                r_valid    = 1'b1;
                r_id       = found_id_reg;
                r_mask     = found_mask_reg;
                r_type     = found_type_reg;
            end
            cfst_pkg::RES_PEND:
            begin
                r_has_slot = 1'b1;
                r_idx      = pend_idx_reg;
                r_valid    = 1'b1;
                r_id       = pend_id_reg;
                r_mask     = pend_mask_reg;
                r_type     = pend_type_reg;
            end
            default:
            begin
                r_has_slot = 1'b0;
            end
        endcase
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    logic [2:0]  status_reg_o;
    logic        valid_reg;
    logic [3:0]  bank_reg;
    logic        slot_reg;
    logic [28:0] eid_reg;
    logic [28:0] emask_reg;
    logic        eext_reg;
    logic [4:0]  total_reg;
    logic [3:0]  banks_reg;
    logic        last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg_o <= cmd.code;
            valid_reg    <= r_valid;
            bank_reg     <= r_has_slot ? 4'({1'b0, r_idx} >> 1) : 4'd0;
            slot_reg     <= r_has_slot ? r_idx[0] : 1'b0;
            eid_reg      <= r_id;
            emask_reg    <= r_mask;
            eext_reg     <= r_type;
            total_reg    <= 5'(act_cnt_reg);
            banks_reg    <= 4'(bank_cnt_reg);
            last_reg     <= cmd.last;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg_o;
    assign entry_valid    = valid_reg;
    assign bank_index     = bank_reg;
    assign slot_index     = slot_reg;
    assign entry_id       = eid_reg;
    assign entry_mask     = emask_reg;
    assign entry_extended = eext_reg;
    assign active_total   = total_reg;
    assign banks_in_use   = banks_reg;
    assign last           = last_reg;

endmodule

// ===== design/cfst_checker.sv =====
// ----------------------------------------------------------------------------
// cfst_checker
// Port-level checks for the filter slot table, bound to the top level.
// ----------------------------------------------------------------------------
module cfst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic        entry_valid,
    input logic [28:0] entry_id,
    input logic [28:0] entry_mask,
    input logic        entry_extended,
    input logic        last
);

    // an accepted command keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    // more results follow a non-final one, so the block is still busy
    a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("non-final result while idle");

    // results without an entry carry zero entry fields
    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !entry_valid |-> (entry_id == 29'd0) && (entry_mask == 29'd0)
                                 && !entry_extended)
        else $error("entry fields set on a result without entry");

    // an entry is only reported with status ok
    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && entry_valid |-> (status == cfst_pkg::STAT_OK))
        else $error("entry reported with failing status");

endmodule

bind can_filter_slot_table cfst_checker u_cfst_checker (.*);
